// ----- rtl/core/cfr_pkg.sv -----
// Shared types and constants for the command frame receiver.
package cfr_pkg;

	localparam int LENGTH_BITS = 12;

	localparam int BYTE_W    = 8;
	localparam int CMD_W     = 4;
	localparam int FIELD_W   = 12;
	localparam int TICK_W    = 4;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0]    SYNC_FIRST_RST  = 8'h1b;
	localparam logic [BYTE_W-1:0]    SYNC_SECOND_RST = 8'hdf;
	localparam logic [TICK_W-1:0]    TIMEOUT_RST     = 4'd10;
	localparam logic [LENGTH_BITS-1:0] MAX_LEN_RST   = LENGTH_BITS'(1535);
	localparam logic [TICK_W-1:0]    TICK_MAX        = 4'hf;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_FIRST  = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_TIMEOUT     = 2'd2,
		REG_MAX_LENGTH  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EV_PAYLOAD   = 3'd0,
		EV_FRAME_OK  = 3'd1,
		EV_CSUM_ERR  = 3'd2,
		EV_TIMEOUT   = 3'd3,
		EV_TOO_LONG  = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'b001,
		PH_CTRL    = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

endpackage

// ----- rtl/core/command_frame_receiver.sv -----
// Top level of the command frame receiver: sync hunt, header decode, payload and checksum.
//
// Usage:
//   s_* channel takes one beat per item: s_tuser is the action (0 byte, 1 timer tick),
//   s_tdata is the received byte. m_* channel returns zero or one result beat per item:
//   m_tuser is the event code, m_tlast marks the beat that ends a frame, m_tdata packs
//   payload_byte, command, frame_length and byte_index.
//   The user writes cfg_* (sync bytes, timeout, max length) only while the block is idle; not enforced.
// Path: each input beat is held in the input register, then decoded into the output
//   register, from which its result, if it has one, leaves.
// Throughput: one beat per cycle unless stalled; the frame state updates in the single decode stage.
// Stall: when m_tready is low and a result waits, the input register holds and s_tready
//   drops once that register is full; nothing is lost or repeated.
// Reset: arst_n clears the frame state to hunting with no byte held, restores the
//   register defaults and empties both registers.
module command_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // rx_byte
	input  logic                        s_tuser,  // action
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [39:0]                 m_tdata,  // payload_byte, command, frame_length, byte_index, zero pad
	output logic [2:0]                  m_tuser,  // event_res
	output logic                        m_tlast,
	input  logic                        cfg_we,
	input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cfr_pkg::CFG_W-1:0]   cfg_data
);
	import cfr_pkg::*;

	logic [BYTE_W-1:0]      sync_first_q, sync_second_q;
	logic [TICK_W-1:0]      timeout_q;
	logic [LENGTH_BITS-1:0] max_len_q;

	logic                   valid_s1;
	logic                   action_s1;
	logic [BYTE_W-1:0]      byte_s1;

	phase_t                 phase_q, phase_d;
	logic                   half_q, half_d;
	logic [BYTE_W-1:0]      held_q, held_d;
	logic [CMD_W-1:0]       cmd_q, cmd_d;
	logic [LENGTH_BITS-1:0] decl_q, decl_d;
	logic [LENGTH_BITS-1:0] seen_q, seen_d;
	logic [BYTE_W-1:0]      xor_q, xor_d;
	logic [TICK_W-1:0]      tick_q, tick_d;

	logic                   res_vld;
	event_t                 res_ev;
	logic [BYTE_W-1:0]      res_byte;
	logic [LENGTH_BITS-1:0] res_idx;
	logic                   res_last;
	logic [TICK_W-1:0]      tick_inc;
	logic [LENGTH_BITS-1:0] hdr_len;

	logic                   out_vld_q;
	event_t                 out_ev_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic [CMD_W-1:0]       out_cmd_q;
	logic [FIELD_W-1:0]     out_len_q;
	logic [FIELD_W-1:0]     out_idx_q;
	logic                   out_last_q;

	logic                   advance;

	assign advance  = valid_s1 && (!out_vld_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			timeout_q     <= TIMEOUT_RST;
			max_len_q     <= MAX_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data[BYTE_W-1:0];
				REG_SYNC_SECOND: sync_second_q <= cfg_data[BYTE_W-1:0];
				REG_TIMEOUT:     timeout_q     <= cfg_data[TICK_W-1:0];
				REG_MAX_LENGTH:  max_len_q     <= cfg_data[LENGTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		half_d   = half_q;
		held_d   = held_q;
		cmd_d    = cmd_q;
		decl_d   = decl_q;
		seen_d   = seen_q;
		xor_d    = xor_q;
		tick_d   = tick_q;
		res_vld  = 1'b0;
		res_ev   = EV_PAYLOAD;
		res_byte = '0;
		res_idx  = seen_q;
		res_last = 1'b0;
		tick_inc = (tick_q == TICK_MAX) ? TICK_MAX : tick_q + TICK_W'(1);
		hdr_len  = LENGTH_BITS'({held_q[3:0], byte_s1});

		if (action_s1) begin
			if (phase_q == PH_PAYLOAD) begin
				tick_d = tick_inc;
				if (tick_inc >= timeout_q) begin
					res_vld  = 1'b1;
					res_ev   = EV_TIMEOUT;
					res_last = 1'b1;
					phase_d  = PH_HUNT;
					half_d   = 1'b0;
					held_d   = '0;
					seen_d   = '0;
					xor_d    = '0;
					tick_d   = '0;
				end
			end
		end else if (phase_q == PH_PAYLOAD) begin
			res_vld = 1'b1;
			if (seen_q < decl_q) begin
				res_ev   = EV_PAYLOAD;
				res_byte = byte_s1;
				xor_d    = xor_q ^ byte_s1;
				seen_d   = seen_q + LENGTH_BITS'(1);
			end else begin
				res_ev   = ((xor_q ^ byte_s1) == '0) ? EV_FRAME_OK : EV_CSUM_ERR;
				res_last = 1'b1;
				phase_d  = PH_HUNT;
				half_d   = 1'b0;
				held_d   = '0;
				seen_d   = '0;
				xor_d    = '0;
				tick_d   = '0;
			end
		end else if (!half_q) begin
			held_d = byte_s1;
			half_d = 1'b1;
		end else begin
			half_d = 1'b0;
			case (phase_q)
				PH_CTRL: begin
					cmd_d  = held_q[7:4];
					decl_d = hdr_len;
					seen_d = '0;
					xor_d  = '0;
					tick_d = '0;
					if (hdr_len > max_len_q) begin
						res_vld  = 1'b1;
						res_ev   = EV_TOO_LONG;
						res_idx  = '0;
						res_last = 1'b1;
						phase_d  = PH_HUNT;
						held_d   = '0;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				default: begin
					phase_d = (held_q == sync_first_q && byte_s1 == sync_second_q) ?
						PH_CTRL : PH_HUNT;
					tick_d  = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			half_q  <= 1'b0;
			held_q  <= '0;
			cmd_q   <= '0;
			decl_q  <= '0;
			seen_q  <= '0;
			xor_q   <= '0;
			tick_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			half_q  <= half_d;
			held_q  <= held_d;
			cmd_q   <= cmd_d;
			decl_q  <= decl_d;
			seen_q  <= seen_d;
			xor_q   <= xor_d;
			tick_q  <= tick_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= res_vld;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_vld) begin
			out_ev_q   <= res_ev;
			out_byte_q <= res_byte;
			out_cmd_q  <= cmd_d;
			out_len_q  <= FIELD_W'(decl_d);
			out_idx_q  <= FIELD_W'(res_idx);
			out_last_q <= res_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_ev_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0000, out_idx_q, out_len_q, out_cmd_q, out_byte_q};

`ifndef ASSERT_OFF
	a_last_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != EV_PAYLOAD)))
		else $error("tlast does not match the end-of-frame event");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_PAYLOAD) |-> (m_tdata[35:24] < m_tdata[23:12]))
		else $error("payload beat index beyond declared length");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != EV_PAYLOAD) |-> (m_tdata[7:0] == '0))
		else $error("nonzero payload byte on an ending beat");

	a_ticks_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_PAYLOAD) |-> (tick_q == '0))
		else $error("tick count nonzero outside payload phase");
`endif

endmodule
